// File: hw/rtl/gpsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gpsd_pkg;

  // default glyph capacity
  localparam int MAX_POINTS_DEF = 2048;

  // fixed field widths
  localparam int CMD_W   = 2;
  localparam int BYTE_W  = 8;
  localparam int CNT_W   = 12;
  localparam int IDX_W   = 11;
  localparam int COORD_W = 16;
  localparam int FLAG_W  = 6;

  // flag bits kept per point
  localparam logic [FLAG_W-1:0] FLAG_CURVE_POINT = 6'h01;
  localparam logic [FLAG_W-1:0] FLAG_X_SHORT     = 6'h02;
  localparam logic [FLAG_W-1:0] FLAG_Y_SHORT     = 6'h04;
  localparam logic [FLAG_W-1:0] FLAG_REPEAT      = 6'h08;
  localparam logic [FLAG_W-1:0] FLAG_X_SAME      = 6'h10;
  localparam logic [FLAG_W-1:0] FLAG_Y_SAME      = 6'h20;

  typedef enum logic [CMD_W-1:0] {
    CMD_START = 2'd0,
    CMD_DATA  = 2'd1,
    CMD_END   = 2'd2,
    CMD_READ  = 2'd3
  } cmd_code_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_FLAGS = 2'd1,
    PH_X     = 2'd2,
    PH_Y     = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_FILL   = 3'd1,
    ST_CHK    = 3'd2,
    ST_FINISH = 3'd3,
    ST_RDOUT  = 3'd4
  } eng_state_t;

  // one accepted input word
  typedef struct packed {
    cmd_code_t          command;
    logic [BYTE_W-1:0]  data_byte;
    logic [CNT_W-1:0]   point_count;
    logic [IDX_W-1:0]   point_index;
  } cmd_t;

  // one result word
  typedef struct packed {
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic                      curve_point;
    logic                      valid_res;
  } rsp_t;

  // short-delta bit for the current axis
  function automatic logic flag_short(input logic [FLAG_W-1:0] f, input phase_t ph);
    flag_short = (ph == PH_X) ? |(f & FLAG_X_SHORT) : |(f & FLAG_Y_SHORT);
  endfunction

  // same / positive bit for the current axis
  function automatic logic flag_same(input logic [FLAG_W-1:0] f, input phase_t ph);
    flag_same = (ph == PH_X) ? |(f & FLAG_X_SAME) : |(f & FLAG_Y_SAME);
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/gpsd_engine.sv
`timescale 1ns / 1ps
`default_nettype none

module gpsd_engine #(
  parameter int MAX_POINTS = gpsd_pkg::MAX_POINTS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cmd_valid,
  input  wire gpsd_pkg::cmd_t cmd,
  output logic               cmd_ready,
  input  wire logic          slot_free,
  output logic               rsp_push,
  output gpsd_pkg::rsp_t     rsp
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = (AW + 1 > gpsd_pkg::CNT_W) ? AW + 1 : gpsd_pkg::CNT_W;
  localparam logic [CW-1:0] MAX_C = CW'(MAX_POINTS);
  localparam int FW = gpsd_pkg::FLAG_W;
  localparam int DW = gpsd_pkg::COORD_W;

  // control registers
  gpsd_pkg::eng_state_t state, state_next;
  gpsd_pkg::phase_t     phase, phase_next;
  logic [CW-1:0]        cursor, cursor_next;
  logic [CW-1:0]        glyph_points, glyph_points_next;
  logic [7:0]           repeat_left, repeat_left_next;
  logic [FW-1:0]        repeat_flag, repeat_flag_next;
  logic                 repeat_pending, repeat_pending_next;
  logic                 fill_zero, fill_zero_next;
  logic [DW-1:0]        acc_x, acc_x_next;
  logic [DW-1:0]        acc_y, acc_y_next;
  logic [7:0]           high_byte, high_byte_next;
  logic                 high_byte_held, high_byte_held_next;
  logic [FW-1:0]        cur_flag, cur_flag_next;
  logic                 rsp_hit, rsp_hit_next;

  // memory ports
  logic [FW-1:0]   flag_mem [MAX_POINTS];
  logic [2*DW-1:0] coord_mem [MAX_POINTS];
  logic            fw_en;
  logic [FW-1:0]   fw_data;
  logic            cw_en_x, cw_en_y;
  logic [DW-1:0]   cw_data;
  logic [AW-1:0]   wr_addr;
  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  logic [FW-1:0]   flag_rd;
  logic [2*DW-1:0] coord_rd;

  // shared decode terms
  logic [CW-1:0] cursor_inc, cursor_after, count_ext, idx_ext;
  logic          cur_lt_gp, inc_lt_gp, after_lt_gp;
  logic          fill_active, flag_rep_new, flag_byte_done;
  logic          rd_hit, chk_zero;
  logic [DW-1:0] acc_sel, byte_delta, coord_sum;
  logic          c_short, c_same;

  assign cursor_inc   = cursor + CW'(1);
  assign cur_lt_gp    = cursor < glyph_points;
  assign inc_lt_gp    = cursor_inc < glyph_points;
  assign cursor_after = cur_lt_gp ? cursor_inc : cursor;
  assign after_lt_gp  = cursor_after < glyph_points;
  assign fill_active  = (repeat_left != 8'd0) && cur_lt_gp;
  assign flag_rep_new = cur_lt_gp && |(cmd.data_byte[FW-1:0] & gpsd_pkg::FLAG_REPEAT);
  assign flag_byte_done = !flag_rep_new && !after_lt_gp;
  assign count_ext    = CW'(cmd.point_count);
  assign idx_ext      = CW'(cmd.point_index);
  assign rd_hit       = (phase == gpsd_pkg::PH_IDLE) && (idx_ext < glyph_points) &&
                        (idx_ext < MAX_C);
  assign chk_zero     = !gpsd_pkg::flag_short(flag_rd, phase) &&
                        gpsd_pkg::flag_same(flag_rd, phase);
  assign acc_sel      = (phase == gpsd_pkg::PH_X) ? acc_x : acc_y;
  assign c_short      = gpsd_pkg::flag_short(cur_flag, phase);
  assign c_same       = gpsd_pkg::flag_same(cur_flag, phase);

  // delta from a data byte: short form signed by the same bit, else big-endian word
  always_comb begin
    if (c_short) begin
      byte_delta = c_same ? {8'h00, cmd.data_byte} : (16'd0 - {8'h00, cmd.data_byte});
    end else begin
      byte_delta = {high_byte, cmd.data_byte};
    end
  end
  assign coord_sum = acc_sel + byte_delta;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      gpsd_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.command)
            gpsd_pkg::CMD_START: state_next = gpsd_pkg::ST_IDLE;
            gpsd_pkg::CMD_DATA: begin
              if (phase == gpsd_pkg::PH_FLAGS) begin
                if (repeat_pending) begin
                  state_next = gpsd_pkg::ST_FILL;
                end else if (flag_byte_done) begin
                  state_next = gpsd_pkg::ST_CHK;
                end
              end else if (phase != gpsd_pkg::PH_IDLE) begin
                if (!cur_lt_gp || c_short || high_byte_held) begin
                  state_next = gpsd_pkg::ST_CHK;
                end
              end
            end
            gpsd_pkg::CMD_END: begin
              if (phase == gpsd_pkg::PH_FLAGS) begin
                state_next = gpsd_pkg::ST_FILL;
              end else if (phase != gpsd_pkg::PH_IDLE) begin
                state_next = gpsd_pkg::ST_FINISH;
              end
            end
            gpsd_pkg::CMD_READ: state_next = gpsd_pkg::ST_RDOUT;
            default: state_next = gpsd_pkg::ST_IDLE;
          endcase
        end
      end
      gpsd_pkg::ST_FILL: begin
        if (fill_zero) begin
          if (!cur_lt_gp) state_next = gpsd_pkg::ST_FINISH;
        end else if (!fill_active) begin
          state_next = cur_lt_gp ? gpsd_pkg::ST_IDLE : gpsd_pkg::ST_CHK;
        end
      end
      gpsd_pkg::ST_CHK: begin
        if (!cur_lt_gp) begin
          if (phase != gpsd_pkg::PH_X) state_next = gpsd_pkg::ST_IDLE;
        end else if (!chk_zero) begin
          state_next = gpsd_pkg::ST_IDLE;
        end
      end
      gpsd_pkg::ST_FINISH: begin
        if (!cur_lt_gp && phase != gpsd_pkg::PH_X) state_next = gpsd_pkg::ST_IDLE;
      end
      gpsd_pkg::ST_RDOUT: begin
        if (slot_free) state_next = gpsd_pkg::ST_IDLE;
      end
      default: state_next = gpsd_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    phase_next          = phase;
    cursor_next         = cursor;
    glyph_points_next   = glyph_points;
    repeat_left_next    = repeat_left;
    repeat_flag_next    = repeat_flag;
    repeat_pending_next = repeat_pending;
    fill_zero_next      = fill_zero;
    acc_x_next          = acc_x;
    acc_y_next          = acc_y;
    high_byte_next      = high_byte;
    high_byte_held_next = high_byte_held;
    cur_flag_next       = cur_flag;
    rsp_hit_next        = rsp_hit;
    cmd_ready           = 1'b0;
    fw_en               = 1'b0;
    fw_data             = repeat_flag;
    cw_en_x             = 1'b0;
    cw_en_y             = 1'b0;
    cw_data             = acc_sel;
    wr_addr             = cursor[AW-1:0];
    rd_en               = 1'b0;
    rd_addr             = cursor_inc[AW-1:0];
    rsp_push            = 1'b0;
    rsp                 = '0;
    unique case (state)
      gpsd_pkg::ST_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          unique case (cmd.command)
            gpsd_pkg::CMD_START: begin
              cursor_next         = '0;
              repeat_left_next    = '0;
              repeat_flag_next    = '0;
              repeat_pending_next = 1'b0;
              acc_x_next          = '0;
              acc_y_next          = '0;
              high_byte_next      = '0;
              high_byte_held_next = 1'b0;
              if (count_ext == '0 || count_ext > MAX_C) begin
                glyph_points_next = '0;
                phase_next        = gpsd_pkg::PH_IDLE;
              end else begin
                glyph_points_next = count_ext;
                phase_next        = gpsd_pkg::PH_FLAGS;
              end
            end
            gpsd_pkg::CMD_DATA: begin
              if (phase == gpsd_pkg::PH_FLAGS) begin
                if (repeat_pending) begin
                  // repeat count: copies go out one per cycle
                  repeat_left_next = cmd.data_byte;
                  fill_zero_next   = 1'b0;
                end else begin
                  if (cur_lt_gp) begin
                    fw_en       = 1'b1;
                    fw_data     = cmd.data_byte[FW-1:0];
                    cursor_next = cursor_inc;
                    if (flag_rep_new) begin
                      repeat_pending_next = 1'b1;
                      repeat_flag_next    = cmd.data_byte[FW-1:0];
                    end
                  end
                  if (flag_byte_done) begin
                    phase_next  = gpsd_pkg::PH_X;
                    cursor_next = '0;
                    rd_en       = 1'b1;
                    rd_addr     = '0;
                  end
                end
              end else if (phase != gpsd_pkg::PH_IDLE && cur_lt_gp) begin
                if (!c_short && !high_byte_held) begin
                  high_byte_next      = cmd.data_byte;
                  high_byte_held_next = 1'b1;
                end else begin
                  high_byte_held_next = 1'b0;
                  cw_en_x     = (phase == gpsd_pkg::PH_X);
                  cw_en_y     = (phase == gpsd_pkg::PH_Y);
                  cw_data     = coord_sum;
                  cursor_next = cursor_inc;
                  rd_en       = inc_lt_gp;
                  if (phase == gpsd_pkg::PH_X) acc_x_next = coord_sum;
                  else                         acc_y_next = coord_sum;
                end
              end
            end
            gpsd_pkg::CMD_END: begin
              if (phase == gpsd_pkg::PH_FLAGS) begin
                repeat_pending_next = 1'b0;
                repeat_left_next    = '0;
                fill_zero_next      = 1'b1;
              end
              high_byte_held_next = 1'b0;
            end
            gpsd_pkg::CMD_READ: begin
              rsp_hit_next = rd_hit;
              rd_en        = rd_hit;
              rd_addr      = idx_ext[AW-1:0];
            end
            default: cmd_ready = 1'b1;
          endcase
        end
      end
      gpsd_pkg::ST_FILL: begin
        if (fill_zero) begin
          // end of data inside the flags: missing flags are zero
          if (cur_lt_gp) begin
            fw_en       = 1'b1;
            fw_data     = '0;
            cursor_next = cursor_inc;
          end else begin
            fill_zero_next = 1'b0;
            phase_next     = gpsd_pkg::PH_X;
            cursor_next    = '0;
          end
        end else if (fill_active) begin
          fw_en            = 1'b1;
          fw_data          = repeat_flag;
          cursor_next      = cursor_inc;
          repeat_left_next = repeat_left - 8'd1;
        end else begin
          repeat_left_next    = '0;
          repeat_pending_next = 1'b0;
          if (!cur_lt_gp) begin
            phase_next  = gpsd_pkg::PH_X;
            cursor_next = '0;
            rd_en       = 1'b1;
            rd_addr     = '0;
          end
        end
      end
      gpsd_pkg::ST_CHK: begin
        // flag of the cursor point arrives from memory; skip points with no bytes
        if (!cur_lt_gp) begin
          cursor_next         = '0;
          high_byte_held_next = 1'b0;
          if (phase == gpsd_pkg::PH_X) begin
            phase_next = gpsd_pkg::PH_Y;
            rd_en      = 1'b1;
            rd_addr    = '0;
          end else begin
            phase_next = gpsd_pkg::PH_IDLE;
          end
        end else if (chk_zero) begin
          cw_en_x     = (phase == gpsd_pkg::PH_X);
          cw_en_y     = (phase == gpsd_pkg::PH_Y);
          cursor_next = cursor_inc;
          rd_en       = inc_lt_gp;
        end else begin
          cur_flag_next = flag_rd;
        end
      end
      gpsd_pkg::ST_FINISH: begin
        // remaining points of both axes take zero deltas
        if (cur_lt_gp) begin
          cw_en_x     = (phase == gpsd_pkg::PH_X);
          cw_en_y     = (phase == gpsd_pkg::PH_Y);
          cursor_next = cursor_inc;
        end else begin
          cursor_next = '0;
          phase_next  = (phase == gpsd_pkg::PH_X) ? gpsd_pkg::PH_Y : gpsd_pkg::PH_IDLE;
        end
      end
      gpsd_pkg::ST_RDOUT: begin
        rsp_push = slot_free;
        if (rsp_hit) begin
          rsp.coord_x     = coord_rd[DW-1:0];
          rsp.coord_y     = coord_rd[2*DW-1:DW];
          rsp.curve_point = |(flag_rd & gpsd_pkg::FLAG_CURVE_POINT);
          rsp.valid_res   = 1'b1;
        end
      end
      default: cmd_ready = 1'b0;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= gpsd_pkg::ST_IDLE;
      phase          <= gpsd_pkg::PH_IDLE;
      cursor         <= '0;
      glyph_points   <= '0;
      repeat_left    <= '0;
      repeat_flag    <= '0;
      repeat_pending <= 1'b0;
      fill_zero      <= 1'b0;
      acc_x          <= '0;
      acc_y          <= '0;
      high_byte      <= '0;
      high_byte_held <= 1'b0;
      cur_flag       <= '0;
      rsp_hit        <= 1'b0;
    end else begin
      state          <= state_next;
      phase          <= phase_next;
      cursor         <= cursor_next;
      glyph_points   <= glyph_points_next;
      repeat_left    <= repeat_left_next;
      repeat_flag    <= repeat_flag_next;
      repeat_pending <= repeat_pending_next;
      fill_zero      <= fill_zero_next;
      acc_x          <= acc_x_next;
      acc_y          <= acc_y_next;
      high_byte      <= high_byte_next;
      high_byte_held <= high_byte_held_next;
      cur_flag       <= cur_flag_next;
      rsp_hit        <= rsp_hit_next;
    end
  end

  // flag memory; a read of the entry written in the same cycle takes the new flag
  always_ff @(posedge clk) begin
    if (fw_en) flag_mem[wr_addr] <= fw_data;
    if (rd_en) begin
      if (fw_en && wr_addr == rd_addr) flag_rd <= fw_data;
      else                             flag_rd <= flag_mem[rd_addr];
    end
  end

  // coordinate memory: y in the upper half, x in the lower, written per half
  always_ff @(posedge clk) begin
    if (cw_en_x) coord_mem[wr_addr][DW-1:0] <= cw_data;
    if (cw_en_y) coord_mem[wr_addr][2*DW-1:DW] <= cw_data;
    if (rd_en) coord_rd <= coord_mem[rd_addr];
  end

  // checks
  a_chk_phase: assert property (@(posedge clk) disable iff (rst)
    state == gpsd_pkg::ST_CHK |-> (phase == gpsd_pkg::PH_X || phase == gpsd_pkg::PH_Y))
    else $error("flag check outside a delta phase");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    cursor <= glyph_points)
    else $error("cursor beyond point count");

  a_half_word: assert property (@(posedge clk) disable iff (rst)
    high_byte_held |-> (phase == gpsd_pkg::PH_X || phase == gpsd_pkg::PH_Y))
    else $error("held high byte outside a delta phase");

  a_repeat: assert property (@(posedge clk) disable iff (rst)
    repeat_pending |-> phase == gpsd_pkg::PH_FLAGS)
    else $error("repeat pending outside the flags");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_push && !rsp.valid_res |->
      (rsp.coord_x == '0 && rsp.coord_y == '0 && !rsp.curve_point))
    else $error("missed read carries nonzero fields");

endmodule

`default_nettype wire

// File: hw/rtl/glyph_point_stream_decoder_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Decodes the point data of a simple TrueType glyph into stored absolute points.
// A start word sets the point count, data words then carry the flag bytes (with
// repeat runs), the x deltas and the y deltas, and an end word completes any
// missing data with zeros. Read words return one point each, with valid_res low
// and the fields zero while decoding is open or the index is out of range. All
// per-point state sits in two memories (flags, and x/y words) with registered
// reads. A flag byte or the high byte of a word delta is taken directly; a short
// delta or the low byte of a word also passes a check step on the next point's
// flag. A repeat count byte starts a fill step that writes the copied flags; the
// end of the flags, each point that needs no delta byte and each axis change add
// a step, as the sequencer walks the flag memory one entry per cycle. An end word
// writes a zero flag for each missing flag and a zero delta for each point still
// open on each axis. A read passes through the memory read register, and its
// result waits in an output register so following words are still taken while
// the result is not yet collected; a further read waits for that slot.
module glyph_point_stream_decoder_unit #(
  parameter int MAX_POINTS = gpsd_pkg::MAX_POINTS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [gpsd_pkg::CMD_W-1:0]          command,
  input  wire logic [gpsd_pkg::BYTE_W-1:0]         data_byte,
  input  wire logic [gpsd_pkg::CNT_W-1:0]          point_count,
  input  wire logic [gpsd_pkg::IDX_W-1:0]          point_index,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [gpsd_pkg::COORD_W-1:0]      coord_x,
  output logic signed [gpsd_pkg::COORD_W-1:0]      coord_y,
  output logic                                     curve_point,
  output logic                                     valid_res
);

  gpsd_pkg::cmd_t cmd;
  gpsd_pkg::rsp_t rsp;
  logic           cmd_ready;
  logic           cmd_valid;
  logic           rsp_push;
  logic           slot_free;

  // input word
  assign cmd.command     = gpsd_pkg::cmd_code_t'(command);
  assign cmd.data_byte   = data_byte;
  assign cmd.point_count = point_count;
  assign cmd.point_index = point_index;
  assign in_stall        = !cmd_ready;
  assign cmd_valid       = in_valid && cmd_ready;

  // output register frees when empty or taken this cycle
  assign slot_free = !out_valid || !out_stall;

  gpsd_engine #(
    .MAX_POINTS (MAX_POINTS)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_ready (cmd_ready),
    .slot_free (slot_free),
    .rsp_push  (rsp_push),
    .rsp       (rsp)
  );

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rsp_push) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (rsp_push) begin
      coord_x     <= rsp.coord_x;
      coord_y     <= rsp.coord_y;
      curve_point <= rsp.curve_point;
      valid_res   <= rsp.valid_res;
    end
  end

endmodule

`default_nettype wire

// File: bench/tb_glyph_point_stream_decoder_unit.sv
`timescale 1ns / 1ps

module tb_glyph_point_stream_decoder_unit;

  localparam int MAX_PTS = gpsd_pkg::MAX_POINTS_DEF;
  localparam int RANDOM_WORDS = 1850;
  localparam int DRAIN_CYCLES = 64;

  // idle percentages per traffic phase
  localparam int GAP_NONE = 0;
  localparam int GAP_HEAVY = 70;
  localparam int GAP_LIGHT = 6;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic in_valid = 1'b0;
  logic in_stall;
  logic [gpsd_pkg::CMD_W-1:0] command = gpsd_pkg::CMD_READ;
  logic [gpsd_pkg::BYTE_W-1:0] data_byte = '0;
  logic [gpsd_pkg::CNT_W-1:0] point_count = '0;
  logic [gpsd_pkg::IDX_W-1:0] point_index = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [gpsd_pkg::COORD_W-1:0] coord_x;
  logic signed [gpsd_pkg::COORD_W-1:0] coord_y;
  logic curve_point;
  logic valid_res;

  glyph_point_stream_decoder_unit u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .command(command),
    .data_byte(data_byte),
    .point_count(point_count),
    .point_index(point_index),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .coord_x(coord_x),
    .coord_y(coord_y),
    .curve_point(curve_point),
    .valid_res(valid_res)
  );

  always #2 clk = ~clk;

  // idling knobs, changed per phase
  int send_gap_pct = GAP_NONE;
  int recv_stall_pct = GAP_NONE;

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // ---------------------------------------------------------------
  // decoder state mirror
  // ---------------------------------------------------------------
  logic [gpsd_pkg::FLAG_W-1:0] flag_mem [MAX_PTS];
  logic [gpsd_pkg::COORD_W-1:0] x_mem [MAX_PTS];
  logic [gpsd_pkg::COORD_W-1:0] y_mem [MAX_PTS];
  gpsd_pkg::phase_t ph = gpsd_pkg::PH_IDLE;
  int cursor = 0;
  int npts = 0;
  bit rep_pending = 1'b0;
  logic [gpsd_pkg::FLAG_W-1:0] rep_flag = '0;
  logic [gpsd_pkg::COORD_W-1:0] acc_x = '0;
  logic [gpsd_pkg::COORD_W-1:0] acc_y = '0;
  logic [gpsd_pkg::BYTE_W-1:0] hi_byte = '0;
  bit hi_held = 1'b0;

  gpsd_pkg::rsp_t pending_points[$];
  int err_count = 0;
  int word_count = 0;

  // delta bytes the current point takes on the current axis
  function automatic int delta_bytes();
    logic [gpsd_pkg::FLAG_W-1:0] short_mask;
    logic [gpsd_pkg::FLAG_W-1:0] same_mask;
    short_mask = (ph == gpsd_pkg::PH_X) ? gpsd_pkg::FLAG_X_SHORT : gpsd_pkg::FLAG_Y_SHORT;
    same_mask = (ph == gpsd_pkg::PH_X) ? gpsd_pkg::FLAG_X_SAME : gpsd_pkg::FLAG_Y_SAME;
    if (|(flag_mem[cursor] & short_mask)) return 1;
    if (|(flag_mem[cursor] & same_mask)) return 0;
    return 2;
  endfunction

  function automatic void store_delta(logic [gpsd_pkg::COORD_W-1:0] d);
    if (ph == gpsd_pkg::PH_X) begin
      acc_x = acc_x + d;
      x_mem[cursor] = acc_x;
    end else begin
      acc_y = acc_y + d;
      y_mem[cursor] = acc_y;
    end
    cursor++;
  endfunction

  // walk over byte-free points and axis ends
  function automatic void skip_free();
    forever begin
      if (ph != gpsd_pkg::PH_X && ph != gpsd_pkg::PH_Y) return;
      if (cursor >= npts) begin
        cursor = 0;
        hi_held = 1'b0;
        if (ph == gpsd_pkg::PH_X) begin
          ph = gpsd_pkg::PH_Y;
          continue;
        end
        ph = gpsd_pkg::PH_IDLE;
        return;
      end
      if (delta_bytes() != 0) return;
      store_delta('0);
    end
  endfunction

  function automatic void take_byte(logic [gpsd_pkg::BYTE_W-1:0] b);
    int n;
    logic [gpsd_pkg::FLAG_W-1:0] f;
    logic [gpsd_pkg::FLAG_W-1:0] same_mask;
    if (ph == gpsd_pkg::PH_FLAGS) begin
      if (rep_pending) begin
        n = b;
        while (n != 0 && cursor < npts) begin
          flag_mem[cursor] = rep_flag;
          cursor++;
          n--;
        end
        rep_pending = 1'b0;
      end else if (cursor < npts) begin
        f = b[gpsd_pkg::FLAG_W-1:0];
        flag_mem[cursor] = f;
        cursor++;
        if (|(f & gpsd_pkg::FLAG_REPEAT)) begin
          rep_pending = 1'b1;
          rep_flag = f;
        end
      end
      if (!rep_pending && cursor >= npts) begin
        ph = gpsd_pkg::PH_X;
        cursor = 0;
        skip_free();
      end
      return;
    end
    if (ph == gpsd_pkg::PH_IDLE) return;
    if (cursor >= npts) begin
      skip_free();
      return;
    end
    same_mask = (ph == gpsd_pkg::PH_X) ? gpsd_pkg::FLAG_X_SAME : gpsd_pkg::FLAG_Y_SAME;
    if (delta_bytes() == 1) begin
      // short delta: same bit picks the sign, negative is the byte negated
      if (|(flag_mem[cursor] & same_mask)) store_delta({8'h00, b});
      else store_delta(-{8'h00, b});
      skip_free();
    end else if (!hi_held) begin
      hi_byte = b;
      hi_held = 1'b1;
    end else begin
      hi_held = 1'b0;
      store_delta({hi_byte, b});
      skip_free();
    end
  endfunction

  // end of data: zero fill whatever is missing
  function automatic void close_glyph();
    if (ph == gpsd_pkg::PH_IDLE) return;
    if (ph == gpsd_pkg::PH_FLAGS) begin
      rep_pending = 1'b0;
      while (cursor < npts) begin
        flag_mem[cursor] = '0;
        cursor++;
      end
      ph = gpsd_pkg::PH_X;
      cursor = 0;
    end
    hi_held = 1'b0;
    while (ph != gpsd_pkg::PH_IDLE) begin
      if (cursor < npts) store_delta('0);
      else skip_free();
    end
  endfunction

  function automatic void decode_word(gpsd_pkg::cmd_code_t c,
                                      logic [gpsd_pkg::BYTE_W-1:0] b,
                                      logic [gpsd_pkg::CNT_W-1:0] cnt,
                                      logic [gpsd_pkg::IDX_W-1:0] idx);
    gpsd_pkg::rsp_t r;
    case (c)
      gpsd_pkg::CMD_START: begin
        cursor = 0;
        rep_pending = 1'b0;
        rep_flag = '0;
        acc_x = '0;
        acc_y = '0;
        hi_byte = '0;
        hi_held = 1'b0;
        if (cnt == 0 || cnt > MAX_PTS) begin
          npts = 0;
          ph = gpsd_pkg::PH_IDLE;
        end else begin
          npts = cnt;
          ph = gpsd_pkg::PH_FLAGS;
        end
      end
      gpsd_pkg::CMD_DATA: take_byte(b);
      gpsd_pkg::CMD_END: close_glyph();
      default: begin
        r = '0;
        if (ph == gpsd_pkg::PH_IDLE && idx < npts) begin
          r.coord_x = x_mem[idx];
          r.coord_y = y_mem[idx];
          r.curve_point = |(flag_mem[idx] & gpsd_pkg::FLAG_CURVE_POINT);
          r.valid_res = 1'b1;
        end
        pending_points.push_back(r);
      end
    endcase
  endfunction

  // ---------------------------------------------------------------
  // driving
  // ---------------------------------------------------------------
  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_word(gpsd_pkg::cmd_code_t c,
                           logic [gpsd_pkg::BYTE_W-1:0] b = '0,
                           logic [gpsd_pkg::CNT_W-1:0] cnt = '0,
                           logic [gpsd_pkg::IDX_W-1:0] idx = '0);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    command <= c;
    data_byte <= b;
    point_count <= cnt;
    point_index <= idx;
    do @(posedge clk); while (in_stall !== 1'b0);
    // data and end words while idle are dropped by the block
    if (!((c == gpsd_pkg::CMD_DATA || c == gpsd_pkg::CMD_END) && ph == gpsd_pkg::PH_IDLE))
      word_count++;
    decode_word(c, b, cnt, idx);
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------
  function automatic void note_failure(string msg);
    err_count++;
    if (err_count <= 10) $display("%0t: %s", $realtime, msg);
  endfunction

  always @(posedge clk) begin : point_check
    gpsd_pkg::rsp_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_points.size() == 0) begin
        note_failure($sformatf("unexpected point word x=%0d y=%0d on=%b ok=%b",
                               coord_x, coord_y, curve_point, valid_res));
      end else begin
        want = pending_points.pop_front();
        if (coord_x !== want.coord_x || coord_y !== want.coord_y ||
            curve_point !== want.curve_point || valid_res !== want.valid_res) begin
          note_failure($sformatf(
            "point mismatch: want x=%0d y=%0d on=%b ok=%b, got x=%0d y=%0d on=%b ok=%b",
            want.coord_x, want.coord_y, want.curve_point, want.valid_res,
            coord_x, coord_y, curve_point, valid_res));
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------
  // full-size glyph closed at once; writes every store entry
  task automatic test_full_glyph();
    send_word(gpsd_pkg::CMD_START, '0, 12'd2048);
    send_word(gpsd_pkg::CMD_END);
    send_word(gpsd_pkg::CMD_READ, '0, '0, 11'd2047);
  endtask

  // zero and oversize counts leave an empty glyph; idle stream ignored
  task automatic test_count_limits();
    send_word(gpsd_pkg::CMD_START, '0, 12'd0);
    send_word(gpsd_pkg::CMD_READ, '0, '0, 11'd0);
    send_word(gpsd_pkg::CMD_START, '0, 12'd4095);
    send_word(gpsd_pkg::CMD_END);
    send_word(gpsd_pkg::CMD_DATA, 8'hA5);
    send_word(gpsd_pkg::CMD_READ, '0, '0, 11'd0);
  endtask

  // short positive, short negative and word deltas
  task automatic test_delta_forms();
    send_word(gpsd_pkg::CMD_START, '0, 12'd2);
    send_word(gpsd_pkg::CMD_DATA, 8'hC3);
    send_word(gpsd_pkg::CMD_DATA, 8'h24);
    send_word(gpsd_pkg::CMD_DATA, 8'hFF);
    send_word(gpsd_pkg::CMD_DATA, 8'h80);
    send_word(gpsd_pkg::CMD_DATA, 8'h00);
    send_word(gpsd_pkg::CMD_DATA, 8'hFF);
    send_word(gpsd_pkg::CMD_DATA, 8'hFF);
    send_word(gpsd_pkg::CMD_DATA, 8'h7F);
    send_word(gpsd_pkg::CMD_READ, '0, '0, 11'd0);
    send_word(gpsd_pkg::CMD_READ, '0, '0, 11'd1);
  endtask

  // surplus repeat, busy read, missing repeat count, restart, half word
  task automatic test_repeat_and_cut();
    send_word(gpsd_pkg::CMD_START, '0, 12'd1);
    send_word(gpsd_pkg::CMD_DATA, 8'h39);
    send_word(gpsd_pkg::CMD_DATA, 8'hFF);
    send_word(gpsd_pkg::CMD_READ, '0, '0, 11'd1);
    send_word(gpsd_pkg::CMD_START, '0, 12'd4);
    send_word(gpsd_pkg::CMD_DATA, 8'h08);
    send_word(gpsd_pkg::CMD_READ, '0, '0, 11'd0);
    send_word(gpsd_pkg::CMD_END);
    send_word(gpsd_pkg::CMD_READ, '0, '0, 11'd3);
    send_word(gpsd_pkg::CMD_START, '0, 12'd4);
    send_word(gpsd_pkg::CMD_DATA, 8'h08);
    send_word(gpsd_pkg::CMD_START, '0, 12'd2);
    send_word(gpsd_pkg::CMD_DATA, 8'h01);
    send_word(gpsd_pkg::CMD_DATA, 8'h01);
    send_word(gpsd_pkg::CMD_DATA, 8'h12);
    send_word(gpsd_pkg::CMD_END);
    send_word(gpsd_pkg::CMD_READ, '0, '0, 11'd1);
  endtask

  // one well-formed glyph with random content, sometimes cut or abandoned
  task automatic random_glyph();
    int n;
    int covered;
    int run;
    int flag_len;
    int cut;
    int nreads;
    bit big;
    logic [7:0] f;
    logic [7:0] stream[$];
    logic [gpsd_pkg::FLAG_W-1:0] pflags[$];
    big = ($urandom_range(0, 99) < 3);
    n = big ? $urandom_range(1025, MAX_PTS) : $urandom_range(1, 16);
    covered = 0;
    // flag section
    while (covered < n) begin
      f = 8'($urandom_range(0, 255));
      if (big) f[3] = 1'b1;
      else if ($urandom_range(0, 99) >= 30) f[3] = 1'b0;
      stream.push_back(f);
      pflags.push_back(f[gpsd_pkg::FLAG_W-1:0]);
      covered++;
      if (f[3]) begin
        if (big) run = $urandom_range(200, 255);
        else if ($urandom_range(0, 9) == 0) run = $urandom_range(0, 255);
        else run = $urandom_range(0, 4);
        stream.push_back(8'(run));
        while (run > 0 && covered < n) begin
          pflags.push_back(f[gpsd_pkg::FLAG_W-1:0]);
          covered++;
          run--;
        end
      end
    end
    flag_len = stream.size();
    // x then y deltas
    foreach (pflags[i]) begin
      if (|(pflags[i] & gpsd_pkg::FLAG_X_SHORT)) stream.push_back(8'($urandom_range(0, 255)));
      else if (!(|(pflags[i] & gpsd_pkg::FLAG_X_SAME))) begin
        stream.push_back(8'($urandom_range(0, 255)));
        stream.push_back(8'($urandom_range(0, 255)));
      end
    end
    foreach (pflags[i]) begin
      if (|(pflags[i] & gpsd_pkg::FLAG_Y_SHORT)) stream.push_back(8'($urandom_range(0, 255)));
      else if (!(|(pflags[i] & gpsd_pkg::FLAG_Y_SAME))) begin
        stream.push_back(8'($urandom_range(0, 255)));
        stream.push_back(8'($urandom_range(0, 255)));
      end
    end
    if (big) cut = flag_len + $urandom_range(0, 12);
    else if ($urandom_range(0, 99) < 20) cut = $urandom_range(0, stream.size() - 1);
    else cut = stream.size();
    if (cut > stream.size()) cut = stream.size();

    send_word(gpsd_pkg::CMD_START, '0, 12'(n));
    for (int i = 0; i < cut; i++) begin
      if ($urandom_range(0, 99) < 3)
        send_word(gpsd_pkg::CMD_READ, '0, '0, 11'($urandom_range(0, 2047)));
      send_word(gpsd_pkg::CMD_DATA, stream[i]);
    end
    // cut short: usually closed by an end word, else abandoned by the next start
    if (cut < stream.size() && $urandom_range(0, 3) != 0) send_word(gpsd_pkg::CMD_END);
    else if ($urandom_range(0, 99) < 5) send_word(gpsd_pkg::CMD_END);

    nreads = $urandom_range(1, 4);
    for (int i = 0; i < nreads; i++) begin
      if ($urandom_range(0, 3) != 0)
        send_word(gpsd_pkg::CMD_READ, '0, '0, 11'($urandom_range(0, n - 1)));
      else
        send_word(gpsd_pkg::CMD_READ, '0, '0, 11'($urandom_range(0, 2047)));
    end
    if ($urandom_range(0, 99) < 5)
      send_word(gpsd_pkg::CMD_DATA, 8'($urandom_range(0, 255)));
  endtask

  task automatic test_random_glyphs(int gap_pct, int stall_pct, int words);
    int stop_at;
    send_gap_pct = gap_pct;
    recv_stall_pct = stall_pct;
    stop_at = word_count + words;
    while (word_count < stop_at) begin
      if ($urandom_range(0, 99) < 4) begin
        // empty glyph from a zero or oversize count
        if ($urandom_range(0, 1) == 0) send_word(gpsd_pkg::CMD_START, '0, 12'd0);
        else send_word(gpsd_pkg::CMD_START, '0, 12'($urandom_range(MAX_PTS + 1, 4095)));
        send_word(gpsd_pkg::CMD_READ, '0, '0, 11'($urandom_range(0, 2047)));
      end else begin
        random_glyph();
      end
    end
  endtask

  // ---------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------
  initial begin
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_full_glyph();
    test_count_limits();
    test_delta_forms();
    test_repeat_and_cut();

    test_random_glyphs(GAP_NONE, GAP_NONE, RANDOM_WORDS / 4);
    test_random_glyphs(GAP_HEAVY, GAP_NONE, RANDOM_WORDS / 4);
    test_random_glyphs(GAP_NONE, GAP_HEAVY, RANDOM_WORDS / 4);
    test_random_glyphs(GAP_LIGHT, GAP_LIGHT, RANDOM_WORDS / 4);

    // last word a read so the queue tracks the block's backlog
    send_word(gpsd_pkg::CMD_READ, '0, '0, 11'd0);
    in_valid <= 1'b0;

    while (pending_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog
  initial begin
    #40_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
